FILE: design/pfg_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the point range/FOV gate.
// Used by every module of the block; depends on nothing.
package pfg_pkg;

    localparam int CoordBitsDef    = 20;
    localparam int CordicStagesDef = 16;
    localparam int LimitBits       = 20;
    localparam int SqBits          = 2 * LimitBits;
    localparam int ClampBits       = 22;
    localparam int ClampMag        = 2097152;
    localparam int D2Bits          = 2 * ClampBits + 2;
    localparam int AngleBits       = 16;
    localparam int PhaseBits       = 32;
    localparam int PreShift        = 24;
    localparam int AddrBits        = 5;
    localparam int DataBits        = 32;

    localparam logic signed [AngleBits-1:0] AngleMin = 16'sh8000;
    localparam logic signed [AngleBits-1:0] AngleMax = 16'sh7fff;
    localparam logic [PhaseBits-1:0] QuarterTurn     = 32'h4000_0000;
    localparam logic [PhaseBits-1:0] ThreeQuarterTurn = 32'hc000_0000;
    localparam logic [PhaseBits-1:0] RoundHalf       = 32'h0000_8000;

    typedef enum logic [2:0] {
        RegDistEn   = 3'd0,
        RegMinRange = 3'd1,
        RegMaxRange = 3'd2,
        RegClear    = 3'd3,
        RegFovLow   = 3'd4,
        RegFovHigh  = 3'd5
    } pfg_reg_t;

    // Control fields that travel with a point down the pipeline.
    typedef struct packed {
        logic [AngleBits-1:0] heading;
        logic                 zero;
        logic                 keep;
        logic                 last;
    } pfg_side_t;

    // Derived range settings handed to the front end.
    typedef struct packed {
        logic                 min_on;
        logic                 max_on;
        logic [SqBits-1:0]    min_sq;
        logic [SqBits-1:0]    max_sq;
        logic [LimitBits-1:0] clear;
    } pfg_cfg_t;

    // atan(2^-i) as a 32-bit binary angle.
    function automatic logic [PhaseBits-1:0] atan_entry(input logic [4:0] idx);
        logic [PhaseBits-1:0] a;
        begin
            case (idx)
                5'd0:    a = 32'd536870912;
                5'd1:    a = 32'd316933406;
                5'd2:    a = 32'd167458907;
                5'd3:    a = 32'd85004756;
                5'd4:    a = 32'd42667331;
                5'd5:    a = 32'd21354465;
                5'd6:    a = 32'd10679838;
                5'd7:    a = 32'd5340245;
                5'd8:    a = 32'd2670163;
                5'd9:    a = 32'd1335087;
                5'd10:   a = 32'd667544;
                5'd11:   a = 32'd333772;
                5'd12:   a = 32'd166886;
                5'd13:   a = 32'd83443;
                5'd14:   a = 32'd41722;
                5'd15:   a = 32'd20861;
                5'd16:   a = 32'd10430;
                5'd17:   a = 32'd5215;
                5'd18:   a = 32'd2608;
                5'd19:   a = 32'd1304;
                5'd20:   a = 32'd652;
                5'd21:   a = 32'd326;
                5'd22:   a = 32'd163;
                5'd23:   a = 32'd81;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

FILE: design/pfg_front.sv
// Front end of the gate: offsets, clamped squares, height test, range test and the
// quadrant pre-rotation that seeds the CORDIC chain. Four register stages.
// Depends on pfg_pkg.
module pfg_front #(
    parameter int COORD_BITS = pfg_pkg::CoordBitsDef,
    localparam int D  = COORD_BITS + 1,
    localparam int W  = COORD_BITS + 27,
    localparam int MW = (D > pfg_pkg::ClampBits) ? D : pfg_pkg::ClampBits,
    localparam int HW = (D > pfg_pkg::LimitBits + 1) ? D : pfg_pkg::LimitBits + 1
) (
    input  logic                                aclk,
    input  logic [3:0]                          ld,
    input  pfg_pkg::pfg_cfg_t                   cfg,
    input  logic [COORD_BITS-1:0]               pt_x,
    input  logic [COORD_BITS-1:0]               pt_y,
    input  logic [COORD_BITS-1:0]               pt_z,
    input  logic [COORD_BITS-1:0]               org_x,
    input  logic [COORD_BITS-1:0]               org_y,
    input  logic [COORD_BITS-1:0]               org_z,
    input  logic [pfg_pkg::AngleBits-1:0]       org_heading,
    input  logic                                cloud_end,
    output logic signed [W-1:0]                 x_out,
    output logic signed [W-1:0]                 y_out,
    output logic [pfg_pkg::PhaseBits-1:0]       z_out,
    output pfg_pkg::pfg_side_t                  side_out,
    output logic [3*COORD_BITS-1:0]             pt_out
);

    // Stage 0: offsets from the origin.
    logic signed [D-1:0]       dx_reg, dy_reg, dz_reg;
    logic [3*COORD_BITS-1:0]   pt0_reg, pt1_reg, pt2_reg, pt3_reg;
    pfg_pkg::pfg_side_t        side0_reg, side1_reg, side2_reg, side3_reg;

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            dx_reg    <= $signed({pt_x[COORD_BITS-1], pt_x}) - $signed({org_x[COORD_BITS-1], org_x});
            dy_reg    <= $signed({pt_y[COORD_BITS-1], pt_y}) - $signed({org_y[COORD_BITS-1], org_y});
            dz_reg    <= $signed({pt_z[COORD_BITS-1], pt_z}) - $signed({org_z[COORD_BITS-1], org_z});
            pt0_reg   <= {pt_z, pt_y, pt_x};
            side0_reg <= '{heading: org_heading, zero: 1'b0, keep: 1'b1, last: cloud_end};
        end
    end

    // Stage 1: clamped squares, height test and CORDIC seed.
    function automatic logic [pfg_pkg::ClampBits-1:0] clamp_mag(input logic signed [D-1:0] d);
        logic [MW-1:0] m;
        begin
            m = d[D-1] ? MW'(-d) : MW'(d);
            return (m > MW'(pfg_pkg::ClampMag)) ? pfg_pkg::ClampBits'(pfg_pkg::ClampMag)
                                                : m[pfg_pkg::ClampBits-1:0];
        end
    endfunction

    logic [pfg_pkg::ClampBits-1:0]   mx, my, mz;
    logic [2*pfg_pkg::ClampBits-1:0] sqx, sqy, sqz;
    logic signed [HW-1:0]            dz_w, clr_w;
    logic                            hdrop;
    logic signed [W-1:0]             ex, ey, sx, sy;
    logic [pfg_pkg::PhaseBits-1:0]   sz;

    assign mx    = clamp_mag(dx_reg);
    assign my    = clamp_mag(dy_reg);
    assign mz    = clamp_mag(dz_reg);
    assign sqx   = mx * mx;
    assign sqy   = my * my;
    assign sqz   = mz * mz;
    assign dz_w  = HW'(dz_reg);
    assign clr_w = $signed(HW'(cfg.clear));
    assign hdrop = (cfg.clear != '0) && (dz_w > clr_w);

    assign ex = $signed({{2{dx_reg[D-1]}}, dx_reg, {pfg_pkg::PreShift{1'b0}}});
    assign ey = $signed({{2{dy_reg[D-1]}}, dy_reg, {pfg_pkg::PreShift{1'b0}}});

    // Points behind the sensor are turned by a quarter turn into the right half plane.
    always_comb begin
        sx = ex;
        sy = ey;
        sz = '0;
        if (ex[W-1]) begin
            if (!ey[W-1]) begin
                sx = ey;
                sy = -ex;
                sz = pfg_pkg::QuarterTurn;
            end else begin
                sx = -ey;
                sy = ex;
                sz = pfg_pkg::ThreeQuarterTurn;
            end
        end
    end

    logic [2*pfg_pkg::ClampBits-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [W-1:0]             x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [pfg_pkg::PhaseBits-1:0]   z1_reg, z2_reg, z3_reg;

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            sqx_reg   <= sqx;
            sqy_reg   <= sqy;
            sqz_reg   <= sqz;
            x1_reg    <= sx;
            y1_reg    <= sy;
            z1_reg    <= sz;
            pt1_reg   <= pt0_reg;
            side1_reg <= '{heading: side0_reg.heading,
                           zero:    (dx_reg == '0) && (dy_reg == '0),
                           keep:    side0_reg.keep & ~hdrop,
                           last:    side0_reg.last};
        end
    end

    // Stage 2: squared distance.
    logic [pfg_pkg::D2Bits-1:0] d2_reg;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            d2_reg    <= pfg_pkg::D2Bits'(sqx_reg) + pfg_pkg::D2Bits'(sqy_reg)
                         + pfg_pkg::D2Bits'(sqz_reg);
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            pt2_reg   <= pt1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: range limits.
    logic rdrop;

    assign rdrop = (cfg.min_on && (d2_reg < pfg_pkg::D2Bits'(cfg.min_sq)))
                || (cfg.max_on && (d2_reg > pfg_pkg::D2Bits'(cfg.max_sq)));

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
            pt3_reg   <= pt2_reg;
            side3_reg <= '{heading: side2_reg.heading,
                           zero:    side2_reg.zero,
                           keep:    side2_reg.keep & ~rdrop,
                           last:    side2_reg.last};
        end
    end

    assign x_out    = x3_reg;
    assign y_out    = y3_reg;
    assign z_out    = z3_reg;
    assign side_out = side3_reg;
    assign pt_out   = pt3_reg;

endmodule

FILE: design/pfg_cell.sv
// One CORDIC vectoring cell: a single micro-rotation by atan(2^-IDX), registered,
// with the point's payload carried alongside. Depends on pfg_pkg.
module pfg_cell #(
    parameter int COORD_BITS = pfg_pkg::CoordBitsDef,
    parameter int IDX        = 0,
    localparam int W         = COORD_BITS + 27
) (
    input  logic                          aclk,
    input  logic                          ld,
    input  logic signed [W-1:0]           x_in,
    input  logic signed [W-1:0]           y_in,
    input  logic [pfg_pkg::PhaseBits-1:0] z_in,
    input  pfg_pkg::pfg_side_t            side_in,
    input  logic [3*COORD_BITS-1:0]       pt_in,
    output logic signed [W-1:0]           x_out,
    output logic signed [W-1:0]           y_out,
    output logic [pfg_pkg::PhaseBits-1:0] z_out,
    output pfg_pkg::pfg_side_t            side_out,
    output logic [3*COORD_BITS-1:0]       pt_out
);

    localparam logic [pfg_pkg::PhaseBits-1:0] Atan = pfg_pkg::atan_entry(5'(IDX));

    logic signed [W-1:0]           xs, ys;
    logic                          ypos;
    logic signed [W-1:0]           x_reg, y_reg;
    logic [pfg_pkg::PhaseBits-1:0] z_reg;
    pfg_pkg::pfg_side_t            side_reg;
    logic [3*COORD_BITS-1:0]       pt_reg;

    assign xs   = x_in >>> IDX;
    assign ys   = y_in >>> IDX;
    assign ypos = !y_in[W-1] && (y_in != '0);

    always_ff @(posedge aclk) begin
        if (ld) begin
            if (ypos) begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + Atan;
            end else begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - Atan;
            end
            side_reg <= side_in;
            pt_reg   <= pt_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;
    assign pt_out   = pt_reg;

endmodule

FILE: design/point_range_fov_gate.sv
// Range, height and field-of-view gate for a stream of lidar points; top level over
// pfg_front and a chain of pfg_cell CORDIC cells, with the pfg_pkg package.
// The block takes one point per clock while s_ready is high and passes each point through
// four front-end stages (offsets, squares, distance sum, range compare), one
// cell per CORDIC iteration for the bearing, and the output register. Every stage has
// its own valid bit, so empty stages keep filling while a result waits on m_ready, and
// a full pipeline moves at one beat per cycle whenever m_ready is high. A register
// write applies in full to points accepted at or after the edge that writes it; write
// the registers only while no point is in flight.
module point_range_fov_gate #(
    parameter int CORDIC_STAGES = pfg_pkg::CordicStagesDef,
    parameter int COORD_BITS    = pfg_pkg::CoordBitsDef
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfg_pkg::AddrBits-1:0]     paddr,
    input  logic [pfg_pkg::DataBits-1:0]     pwdata,
    output logic [pfg_pkg::DataBits-1:0]     prdata,
    output logic                             pready,
    // point input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [COORD_BITS-1:0]            s_pt_x,
    input  logic [COORD_BITS-1:0]            s_pt_y,
    input  logic [COORD_BITS-1:0]            s_pt_z,
    input  logic [COORD_BITS-1:0]            s_org_x,
    input  logic [COORD_BITS-1:0]            s_org_y,
    input  logic [COORD_BITS-1:0]            s_org_z,
    input  logic [pfg_pkg::AngleBits-1:0]    s_org_heading,
    input  logic                             s_cloud_end,
    // result output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_keep,
    output logic [COORD_BITS-1:0]            m_out_x,
    output logic [COORD_BITS-1:0]            m_out_y,
    output logic [COORD_BITS-1:0]            m_out_z,
    output logic                             m_out_end
);

    localparam int W  = COORD_BITS + 27;
    localparam int N  = CORDIC_STAGES;
    localparam int NS = N + 5;

    // ---------------- configuration registers ----------------
    logic                                  dist_en_reg;
    logic [pfg_pkg::LimitBits-1:0]         min_reg, max_reg, clear_reg;
    logic signed [pfg_pkg::AngleBits-1:0]  fov_lo_reg, fov_hi_reg;
    logic [pfg_pkg::SqBits-1:0]            min_sq_reg, max_sq_reg;
    pfg_pkg::pfg_reg_t                     reg_idx;
    logic                                  wr_en;

    assign reg_idx = pfg_pkg::pfg_reg_t'(paddr[pfg_pkg::AddrBits-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_en_reg <= 1'b0;
            min_reg     <= '0;
            max_reg     <= '0;
            clear_reg   <= '0;
            fov_lo_reg  <= pfg_pkg::AngleMin;
            fov_hi_reg  <= pfg_pkg::AngleMax;
        end else if (wr_en) begin
            case (reg_idx)
                pfg_pkg::RegDistEn:   dist_en_reg <= pwdata[0];
                pfg_pkg::RegMinRange: min_reg     <= pwdata[pfg_pkg::LimitBits-1:0];
                pfg_pkg::RegMaxRange: max_reg     <= pwdata[pfg_pkg::LimitBits-1:0];
                pfg_pkg::RegClear:    clear_reg   <= pwdata[pfg_pkg::LimitBits-1:0];
                pfg_pkg::RegFovLow:   fov_lo_reg  <= pwdata[pfg_pkg::AngleBits-1:0];
                pfg_pkg::RegFovHigh:  fov_hi_reg  <= pwdata[pfg_pkg::AngleBits-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pfg_pkg::RegDistEn:   prdata = pfg_pkg::DataBits'(dist_en_reg);
            pfg_pkg::RegMinRange: prdata = pfg_pkg::DataBits'(min_reg);
            pfg_pkg::RegMaxRange: prdata = pfg_pkg::DataBits'(max_reg);
            pfg_pkg::RegClear:    prdata = pfg_pkg::DataBits'(clear_reg);
            pfg_pkg::RegFovLow:   prdata = pfg_pkg::DataBits'(fov_lo_reg);
            pfg_pkg::RegFovHigh:  prdata = pfg_pkg::DataBits'(fov_hi_reg);
            default:              prdata = '0;
        endcase
    end

    // The squared limits are refreshed every cycle from the limit registers.
    always_ff @(posedge aclk) begin
        min_sq_reg <= min_reg * min_reg;
        max_sq_reg <= max_reg * max_reg;
    end

    pfg_pkg::pfg_cfg_t cfg;
    logic              fov_on;

    assign cfg.min_on = dist_en_reg && (min_reg != '0);
    assign cfg.max_on = dist_en_reg && (max_reg != '0);
    assign cfg.min_sq = min_sq_reg;
    assign cfg.max_sq = max_sq_reg;
    assign cfg.clear  = clear_reg;
    assign fov_on     = (fov_lo_reg != pfg_pkg::AngleMin) && (fov_hi_reg != pfg_pkg::AngleMax)
                     && (fov_hi_reg > fov_lo_reg);

    // ---------------- pipeline flow control ----------------
    // A stage loads when it is empty or the stage after it moves on.
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS:0]   rdy;

    assign rdy[NS] = m_ready;
    for (genvar g = 0; g < NS; g++) begin : g_rdy
        assign rdy[g] = !valid_reg[g] || rdy[g+1];
    end

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
                valid_next[i] = (i == 0) ? s_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = valid_reg[NS-1];

    // ---------------- datapath ----------------
    logic signed [W-1:0]           cx [0:N];
    logic signed [W-1:0]           cy [0:N];
    logic [pfg_pkg::PhaseBits-1:0] cz [0:N];
    pfg_pkg::pfg_side_t            cs [0:N];
    logic [3*COORD_BITS-1:0]       cp [0:N];

    pfg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .ld          (rdy[3:0]),
        .cfg         (cfg),
        .pt_x        (s_pt_x),
        .pt_y        (s_pt_y),
        .pt_z        (s_pt_z),
        .org_x       (s_org_x),
        .org_y       (s_org_y),
        .org_z       (s_org_z),
        .org_heading (s_org_heading),
        .cloud_end   (s_cloud_end),
        .x_out       (cx[0]),
        .y_out       (cy[0]),
        .z_out       (cz[0]),
        .side_out    (cs[0]),
        .pt_out      (cp[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        pfg_cell #(
            .COORD_BITS (COORD_BITS),
            .IDX        (g)
        ) u_cell (
            .aclk     (aclk),
            .ld       (rdy[g+4]),
            .x_in     (cx[g]),
            .y_in     (cy[g]),
            .z_in     (cz[g]),
            .side_in  (cs[g]),
            .pt_in    (cp[g]),
            .x_out    (cx[g+1]),
            .y_out    (cy[g+1]),
            .z_out    (cz[g+1]),
            .side_out (cs[g+1]),
            .pt_out   (cp[g+1])
        );
    end

    // Output stage: round the bearing, take it relative to heading, test the window.
    logic [pfg_pkg::PhaseBits-1:0]        bsum;
    logic [pfg_pkg::AngleBits-1:0]        bearing;
    logic signed [pfg_pkg::AngleBits-1:0] rel;
    logic                                 fdrop;

    assign bsum    = cz[N] + pfg_pkg::RoundHalf;
    assign bearing = cs[N].zero ? '0 : bsum[pfg_pkg::PhaseBits-1 -: pfg_pkg::AngleBits];
    assign rel     = $signed(bearing - cs[N].heading);
    assign fdrop   = fov_on && ((rel < fov_lo_reg) || (rel > fov_hi_reg));

    // cx and cy of the last cell are not needed; x and y leave the chain here.
    logic keep_reg, end_reg;
    logic [COORD_BITS-1:0] ox_reg, oy_reg, oz_reg;

    always_ff @(posedge aclk) begin
        if (rdy[NS-1]) begin
            keep_reg <= cs[N].keep & ~fdrop;
            end_reg  <= cs[N].last;
            ox_reg   <= cp[N][COORD_BITS-1:0];
            oy_reg   <= cp[N][2*COORD_BITS-1:COORD_BITS];
            oz_reg   <= cp[N][3*COORD_BITS-1:2*COORD_BITS];
        end
    end

    assign m_keep    = keep_reg;
    assign m_out_end = end_reg;
    assign m_out_x   = ox_reg;
    assign m_out_y   = oy_reg;
    assign m_out_z   = oz_reg;

endmodule

FILE: dv/point_range_fov_gate_test.sv
// Self-checking bench for point_range_fov_gate: directed and random points under several
// APB settings, checked against an in-bench model of the range, height and bearing tests.
// Depends on pfg_pkg and the point_range_fov_gate RTL.

localparam int CoordW       = pfg_pkg::CoordBitsDef;
localparam int CordicStages = pfg_pkg::CordicStagesDef;
localparam longint unsigned ClampCm = 64'd2097152;

// atan(2^-i) in 32-bit binary angles, one entry per CORDIC iteration.
localparam logic [31:0] CordicTurns [CordicStages] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
};

typedef struct packed {
    logic signed [CoordW-1:0]             pt_x;
    logic signed [CoordW-1:0]             pt_y;
    logic signed [CoordW-1:0]             pt_z;
    logic signed [CoordW-1:0]             org_x;
    logic signed [CoordW-1:0]             org_y;
    logic signed [CoordW-1:0]             org_z;
    logic signed [pfg_pkg::AngleBits-1:0] heading;
    logic                                 cloud_end;
} point_t;

typedef struct packed {
    logic              keep;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              last;
} gate_out_t;

class gate_scoreboard;
    bit                                   dist_en;
    longint unsigned                      min_cm;
    longint unsigned                      max_cm;
    longint unsigned                      clear_cm;
    logic signed [pfg_pkg::AngleBits-1:0] fov_lo;
    logic signed [pfg_pkg::AngleBits-1:0] fov_hi;
    gate_out_t                            due[$];
    int unsigned                          taken;
    int unsigned                          checked;
    int unsigned                          kept;
    int unsigned                          fails;

    function new();
        dist_en  = 1'b0;
        min_cm   = 0;
        max_cm   = 0;
        clear_cm = 0;
        fov_lo   = pfg_pkg::AngleMin;
        fov_hi   = pfg_pkg::AngleMax;
    endfunction

    function void set_reg(pfg_pkg::pfg_reg_t r, logic [31:0] v);
        case (r)
            pfg_pkg::RegDistEn:   dist_en  = v[0];
            pfg_pkg::RegMinRange: min_cm   = 64'(v[19:0]);
            pfg_pkg::RegMaxRange: max_cm   = 64'(v[19:0]);
            pfg_pkg::RegClear:    clear_cm = 64'(v[19:0]);
            pfg_pkg::RegFovLow:   fov_lo   = v[15:0];
            pfg_pkg::RegFovHigh:  fov_hi   = v[15:0];
            default: ;
        endcase
    endfunction

    function longint unsigned clamp_sq(longint d);
        longint unsigned a;
        a = (d < 0) ? longint'(-d) : longint'(d);
        if (a > ClampCm) a = ClampCm;
        return a * a;
    endfunction

    // Works out the keep flag of an accepted point and queues the expected beat.
    function void note_point(point_t p);
        longint dx, dy, dz, x, y, t, xs, ys;
        longint unsigned d2;
        logic [31:0] z;
        logic [15:0] bear;
        logic signed [15:0] diff;
        bit min_on, max_on, fov_on, keep;
        gate_out_t e;
        dx = longint'(p.pt_x) - longint'(p.org_x);
        dy = longint'(p.pt_y) - longint'(p.org_y);
        dz = longint'(p.pt_z) - longint'(p.org_z);
        min_on = dist_en && min_cm != 0;
        max_on = dist_en && max_cm != 0;
        fov_on = fov_lo != pfg_pkg::AngleMin && fov_hi != pfg_pkg::AngleMax &&
                 fov_hi > fov_lo;
        keep = 1'b1;
        if (min_on || max_on) begin
            d2 = clamp_sq(dx) + clamp_sq(dy) + clamp_sq(dz);
            if (min_on && d2 < min_cm * min_cm) keep = 1'b0;
            if (max_on && d2 > max_cm * max_cm) keep = 1'b0;
        end
        if (clear_cm != 0 && dz > longint'(clear_cm)) keep = 1'b0;
        if (fov_on) begin
            // Vectoring CORDIC for atan2(dy, dx); left half-plane is pre-rotated by 90 degrees.
            z = '0;
            if (dx == 0 && dy == 0) begin
                bear = '0;
            end else begin
                x = dx * 64'sd16777216;
                y = dy * 64'sd16777216;
                if (x < 0) begin
                    t = x;
                    if (y >= 0) begin
                        x = y;
                        y = -t;
                        z = 32'h4000_0000;
                    end else begin
                        x = -y;
                        y = t;
                        z = 32'hc000_0000;
                    end
                end
                for (int i = 0; i < CordicStages; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y > 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + CordicTurns[i];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - CordicTurns[i];
                    end
                end
                z = z + 32'h0000_8000;
                bear = z[31:16];
            end
            diff = bear - p.heading;
            if (diff < fov_lo || diff > fov_hi) keep = 1'b0;
        end
        e.keep = keep;
        e.x    = p.pt_x;
        e.y    = p.pt_y;
        e.z    = p.pt_z;
        e.last = p.cloud_end;
        due = {due, e};
        taken++;
    endfunction

    function void report(string field, longint want, longint got);
        fails++;
        if (fails <= 20)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_output(gate_out_t got);
        gate_out_t want;
        if (due.size() == 0) begin
            fails++;
            $display("%0t: result beat with nothing pending, actual %0h", $time, got);
            return;
        end
        want = due.pop_front();
        checked++;
        if (got.keep === 1'b1) kept++;
        if (got.keep !== want.keep) report("keep", want.keep, got.keep);
        if (got.x !== want.x) report("out_x", want.x, got.x);
        if (got.y !== want.y) report("out_y", want.y, got.y);
        if (got.z !== want.z) report("out_z", want.z, got.z);
        if (got.last !== want.last) report("out_end", want.last, got.last);
    endfunction
endclass

module point_range_fov_gate_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod   = 10;
    localparam int PipeDepth   = CordicStages + 5;
    localparam int QuietLimit  = 2000;
    localparam int RandPhases  = 8;
    localparam int PhasePoints = 56;

    typedef enum int {
        ReadyAlways,
        ReadyCoin,
        ReadyThreeOfFour,
        ReadyTrickle
    } ready_mode_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [pfg_pkg::AddrBits-1:0]   paddr;
    logic [pfg_pkg::DataBits-1:0]   pwdata;
    logic [pfg_pkg::DataBits-1:0]   prdata;
    logic                           pready;
    logic                           s_valid;
    logic                           s_ready;
    logic [CoordW-1:0]              s_pt_x;
    logic [CoordW-1:0]              s_pt_y;
    logic [CoordW-1:0]              s_pt_z;
    logic [CoordW-1:0]              s_org_x;
    logic [CoordW-1:0]              s_org_y;
    logic [CoordW-1:0]              s_org_z;
    logic [pfg_pkg::AngleBits-1:0]  s_org_heading;
    logic                           s_cloud_end;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_keep;
    logic [CoordW-1:0]              m_out_x;
    logic [CoordW-1:0]              m_out_y;
    logic [CoordW-1:0]              m_out_z;
    logic                           m_out_end;

    gate_scoreboard sb = new();
    int          burst_left  = 0;
    int          quiet_cycles = 0;
    int          settings    = 1;
    int          ready_left  = 0;
    ready_mode_t ready_mode  = ReadyAlways;

    point_range_fov_gate dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pt_x        (s_pt_x),
        .s_pt_y        (s_pt_y),
        .s_pt_z        (s_pt_z),
        .s_org_x       (s_org_x),
        .s_org_y       (s_org_y),
        .s_org_z       (s_org_z),
        .s_org_heading (s_org_heading),
        .s_cloud_end   (s_cloud_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_keep        (m_keep),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .m_out_end     (m_out_end)
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    // Receiver: holds one stall style for a random stretch, then picks another.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(8, 80);
        end
        ready_left--;
        case (ready_mode)
            ReadyAlways:      m_ready = 1'b1;
            ReadyCoin:        m_ready = ($urandom_range(0, 1) == 1);
            ReadyThreeOfFour: m_ready = (ready_left % 4) != 0;
            default:          m_ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output({m_keep, m_out_x, m_out_y, m_out_z, m_out_end});
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles == QuietLimit) begin
            $display("%0t: no beat on either channel for %0d cycles", $time, QuietLimit);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input pfg_pkg::pfg_reg_t r, input logic [31:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 2'b00};
        pwdata  = v;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(r, v);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        // Leave the bus idle so the new value is live before the next point.
        @(negedge aclk);
    endtask

    // Registers change only once every point in flight has come back out.
    task automatic load_setting(input bit en, input int unsigned min_cm, input int unsigned max_cm,
                                input int unsigned clear_cm, input int lo, input int hi);
        s_valid = 1'b0;
        while (sb.due.size() != 0) @(negedge aclk);
        write_reg(pfg_pkg::RegDistEn, 32'(en));
        write_reg(pfg_pkg::RegMinRange, min_cm);
        write_reg(pfg_pkg::RegMaxRange, max_cm);
        write_reg(pfg_pkg::RegClear, clear_cm);
        write_reg(pfg_pkg::RegFovLow, lo);
        write_reg(pfg_pkg::RegFovHigh, hi);
        settings++;
    endtask

    task automatic send_point(input point_t p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 16);
        end
        burst_left--;
        s_pt_x        = p.pt_x;
        s_pt_y        = p.pt_y;
        s_pt_z        = p.pt_z;
        s_org_x       = p.org_x;
        s_org_y       = p.org_y;
        s_org_z       = p.org_z;
        s_org_heading = p.heading;
        s_cloud_end   = p.cloud_end;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_point(p);
        @(negedge aclk);
    endtask

    function automatic point_t make_point(int px, int py, int pz, int ox, int oy, int oz,
                                          int hd, bit last);
        point_t p;
        p.pt_x      = CoordW'(px);
        p.pt_y      = CoordW'(py);
        p.pt_z      = CoordW'(pz);
        p.org_x     = CoordW'(ox);
        p.org_y     = CoordW'(oy);
        p.org_z     = CoordW'(oz);
        p.heading   = pfg_pkg::AngleBits'(hd);
        p.cloud_end = last;
        return p;
    endfunction

    function automatic int spread(int k);
        return int'($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1));
    endfunction

    function automatic int unsigned pick_limit();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 20'hfffff;
            2:       return 1;
            default: return $urandom_range(0, (1 << $urandom_range(4, 20)) - 1);
        endcase
    endfunction

    // Most points sit at an offset from the origin on a random scale, so that the range
    // and height limits split them; the rest are random in every field.
    function automatic point_t random_point();
        point_t p;
        int k;
        p.org_x     = CoordW'($urandom);
        p.org_y     = CoordW'($urandom);
        p.org_z     = CoordW'($urandom);
        p.heading   = pfg_pkg::AngleBits'($urandom);
        p.cloud_end = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 4) == 0) begin
            p.pt_x = CoordW'($urandom);
            p.pt_y = CoordW'($urandom);
            p.pt_z = CoordW'($urandom);
        end else begin
            k = $urandom_range(2, 20);
            p.pt_x = CoordW'(int'(p.org_x) + spread(k));
            p.pt_y = CoordW'(int'(p.org_y) + spread(k));
            p.pt_z = CoordW'(int'(p.org_z) + spread(k));
            if ($urandom_range(0, 19) == 0) begin
                p.pt_x = p.org_x;
                p.pt_y = p.org_y;
            end
        end
        return p;
    endfunction

    task automatic random_setting();
        int lo, hi;
        case ($urandom_range(0, 5))
            0: begin
                lo = -32768;
                hi = $urandom_range(0, 65535) - 32768;
            end
            1: begin
                lo = $urandom_range(0, 65535) - 32768;
                hi = 32767;
            end
            2: begin
                lo = $urandom_range(0, 65535) - 32768;
                hi = lo;
            end
            3: begin
                hi = $urandom_range(0, 32766) - 32767;
                lo = hi + $urandom_range(1, 32767);
            end
            default: begin
                lo = $urandom_range(0, 65533) - 32767;
                hi = lo + $urandom_range(1, 1 << $urandom_range(6, 15));
                if (hi > 32766) hi = 32766;
            end
        endcase
        load_setting($urandom_range(0, 3) != 0, pick_limit(), pick_limit(), pick_limit(), lo, hi);
    endtask

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_pt_x        = '0;
        s_pt_y        = '0;
        s_pt_z        = '0;
        s_org_x       = '0;
        s_org_y       = '0;
        s_org_z       = '0;
        s_org_heading = '0;
        s_cloud_end   = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: every test off, so field extremes must all be kept.
        send_point(make_point(524287, 524287, 524287, -524288, -524288, -524288, 32767, 1));
        send_point(make_point(-524288, -524288, -524288, 524287, 524287, 524287, -32768, 0));
        send_point(make_point(0, 0, 0, 0, 0, 0, 0, 1));
        send_point(make_point(-1, -1, -1, -1, -1, -1, -1, 0));

        // Range limits hit exactly and by one, height at the clearance, a window of
        // plus and minus 45 degrees around the heading.
        load_setting(1'b1, 1000, 50000, 300, -8192, 8192);
        send_point(make_point(1100, 200, -50, 100, 200, -50, 0, 0));
        send_point(make_point(1099, 200, -50, 100, 200, -50, 0, 0));
        send_point(make_point(50100, 200, -50, 100, 200, -50, 0, 0));
        send_point(make_point(50101, 200, -50, 100, 200, -50, 0, 1));
        send_point(make_point(2100, 200, 250, 100, 200, -50, 0, 0));
        send_point(make_point(2100, 200, 251, 100, 200, -50, 0, 0));
        send_point(make_point(100, 2200, -50, 100, 200, -50, 0, 0));
        send_point(make_point(-1900, -1800, -50, 100, 200, -50, 0, 0));
        send_point(make_point(-1900, 200, -50, 100, 200, -50, -32768, 0));
        send_point(make_point(100, 2200, -50, 100, 200, -50, 16384, 0));
        send_point(make_point(-1900, 230, -50, 100, 200, -50, 32767, 0));
        // No offset in x and y: bearing is zero, point sits well below the origin.
        send_point(make_point(100, 200, -2050, 100, 200, -50, 0, 1));

        // Largest limits and the widest window that still counts as on.
        load_setting(1'b1, 20'hfffff, 20'hfffff, 20'hfffff, -32767, 32766);
        send_point(make_point(524287, 524287, 524287, -524288, -524288, -524288, 0, 0));
        send_point(make_point(524287, 0, 0, -524288, 0, 0, 0, 0));
        send_point(make_point(524287, 0, 0, -524288, 0, 0, 32767, 0));
        send_point(make_point(524287, 0, 0, -524288, 0, 0, -32768, 1));

        // Range limits set but disabled, smallest clearance, window off by its low limit.
        load_setting(1'b0, 5, 6, 1, -32768, 100);
        send_point(make_point(0, 0, 1, 0, 0, 0, 0, 0));
        send_point(make_point(0, 0, 2, 0, 0, 0, 0, 0));
        send_point(make_point(400000, -400000, -400000, -100, 100, 0, 5000, 1));

        for (int ph = 0; ph < RandPhases; ph++) begin
            random_setting();
            for (int n = 0; n < PhasePoints; n++) send_point(random_point());
        end

        s_valid = 1'b0;
        while (sb.due.size() != 0) @(negedge aclk);
        repeat (PipeDepth + 8) @(negedge aclk);

        $display("%0d points under %0d register settings, %0d results checked, %0d kept",
                 sb.taken, settings, sb.checked, sb.kept);
        if (sb.fails == 0 && sb.due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.fails, sb.due.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: files.f
design/pfg_pkg.sv
design/pfg_front.sv
design/pfg_cell.sv
design/point_range_fov_gate.sv
dv/point_range_fov_gate_test.sv
